### rtl/lpl_pkg.sv
package lpl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int MIN_LOOKAHEAD = 16;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;

  // quotient bits produced by the divider (needed gain is always below unity)
  localparam logic [3:0] DIV_STEPS = 4'd15;

  typedef enum logic [1:0] {
    REG_CEILING   = 2'd0,
    REG_RELEASE   = 2'd1,
    REG_LOOKAHEAD = 2'd2,
    REG_STEREO    = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV_WAIT,
    ST_REL_MUL,
    ST_REL_ADD,
    ST_MUL_L,
    ST_SAT_L,
    ST_MUL_R,
    ST_SAT_R,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic start;
    logic [GAIN_W-1:0] ceiling;
    logic [SAMPLE_W-1:0] peak;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [GAIN_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/lpl_ram.sv
module lpl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/lpl_div.sv
module lpl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lpl_pkg::div_req_t req,
  output lpl_pkg::div_rsp_t rsp
);

  // dividend is ceiling * 2^23; its part above bit 15 (ceiling * 256) is below
  // the divisor, so only the low fifteen quotient bits are produced
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [3:0]                    cnt_r, cnt_nxt;
  logic [lpl_pkg::SAMPLE_W:0]    rem_r, rem_nxt;
  logic [lpl_pkg::GAIN_W-1:0]    q_r, q_nxt;
  logic [lpl_pkg::SAMPLE_W-1:0]  dvs_r, dvs_nxt;
  logic [lpl_pkg::SAMPLE_W+1:0]  shifted;
  logic [lpl_pkg::SAMPLE_W+1:0]  diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {2'b00, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      rem_nxt  = {1'b0, req.ceiling, 8'd0};
      q_nxt    = '0;
      dvs_nxt  = req.peak;
    end else if (busy_r) begin
      // restoring step: shift in a zero, subtract when it fits
      if (!diff[lpl_pkg::SAMPLE_W+1]) begin
        rem_nxt = diff[lpl_pkg::SAMPLE_W:0];
        q_nxt   = {q_r[lpl_pkg::GAIN_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[lpl_pkg::SAMPLE_W:0];
        q_nxt   = {q_r[lpl_pkg::GAIN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == lpl_pkg::DIV_STEPS - 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

### rtl/lookahead_peak_limiter_unit.sv
// Lookahead peak limiter, one stereo pair per word.
// in_*  : stream slave, one word = {right_in, left_in}. The pair is written
//         into the delay memory and the pair stored at the write position
//         comes back out, scaled by the limiter gain.
// out_* : stream master, one word = {applied_gain, right_out, left_out}.
// cfg_* : APB-style register port, pready tied high; write only while idle.
// Per word, the peak scan reads the whole window through the single read port
// of the delay memory, one entry a cycle; then, if the peak is over the
// ceiling, a 15-step divider forms ceiling / peak, and one shared multiplier
// scales left and, in stereo mode, right in turn. One word is in work at a time.
// The output register holds a finished word, so the next input word is
// taken and processed while the receiver stalls; the block waits only when
// a second result is ready before the first was taken.
// Reset: registers return to their defaults, gain to unity, write position
// to zero, and a clearing pass zeroes the delay memory, one entry a cycle,
// with in_tready low. Configuration writes are taken during that pass.
module lookahead_peak_limiter_unit #(
  parameter int MAX_LOOKAHEAD = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [23:0] left_in, [47:24] right_in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata: [23:0] left_out, [47:24] right_out, [63:48] applied_gain
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW  = lpl_pkg::SAMPLE_W;
  localparam int GW  = lpl_pkg::GAIN_W;
  localparam int AW  = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int LCW = ($clog2(MAX_LOOKAHEAD + 1) > 9) ? $clog2(MAX_LOOKAHEAD + 1) : 9;
  localparam int MW  = 2 * SW;
  localparam int PW  = SW + GW + 1;

  // ---------------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------------
  logic [GW-1:0] ceil_r;
  logic [GW-1:0] rel_coef_r;
  logic [8:0]    look_len_r;
  logic          stereo_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r     <= 16'd29205;
      rel_coef_r <= 16'd65518;
      look_len_r <= 9'd240;
      stereo_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (lpl_pkg::reg_idx_t'(cfg_paddr[3:2]))
        lpl_pkg::REG_CEILING:   ceil_r     <= cfg_pwdata[GW-1:0];
        lpl_pkg::REG_RELEASE:   rel_coef_r <= cfg_pwdata[GW-1:0];
        lpl_pkg::REG_LOOKAHEAD: look_len_r <= cfg_pwdata[8:0];
        lpl_pkg::REG_STEREO:    stereo_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lpl_pkg::reg_idx_t'(cfg_paddr[3:2]))
      lpl_pkg::REG_CEILING:   cfg_prdata = {16'd0, ceil_r};
      lpl_pkg::REG_RELEASE:   cfg_prdata = {16'd0, rel_coef_r};
      lpl_pkg::REG_LOOKAHEAD: cfg_prdata = {23'd0, look_len_r};
      lpl_pkg::REG_STEREO:    cfg_prdata = {31'd0, stereo_r};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // clamp the window to [MIN_LOOKAHEAD, MAX_LOOKAHEAD]
  logic [LCW-1:0] len_raw;
  logic [LCW-1:0] len_eff;
  logic [LCW-1:0] last_idx;

  always_comb begin
    len_raw = LCW'(look_len_r);
    if (len_raw < LCW'(lpl_pkg::MIN_LOOKAHEAD)) begin
      len_eff = LCW'(lpl_pkg::MIN_LOOKAHEAD);
    end else if (len_raw > LCW'(MAX_LOOKAHEAD)) begin
      len_eff = LCW'(MAX_LOOKAHEAD);
    end else begin
      len_eff = len_raw;
    end
    last_idx = len_eff - LCW'(1);
  end

  // ---------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------
  function automatic logic [SW-1:0] mag(input logic [SW-1:0] s);
    mag = s[SW-1] ? (~s + SW'(1)) : s;
  endfunction

  // round half up, shift out Q15, saturate to 24 bits
  function automatic logic [SW-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW:0]   t;
    logic signed [SW+2:0] r;
    t = $signed({p[PW-1], p}) + $signed((PW+1)'(16384));
    r = (SW+3)'(t >>> 15);
    if (r > $signed((SW+3)'(8388607))) begin
      round_sat = 24'h7FFFFF;
    end else if (r < -$signed((SW+3)'(8388608))) begin
      round_sat = 24'h800000;
    end else begin
      round_sat = r[SW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // datapath state
  // ---------------------------------------------------------------------
  lpl_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [GW-1:0]        att_r, att_nxt;
  logic [SW-1:0]        l_in_r, l_in_nxt;
  logic [SW-1:0]        r_in_r, r_in_nxt;
  logic [SW-1:0]        l_old_r, l_old_nxt;
  logic [SW-1:0]        r_old_r, r_old_nxt;
  logic [AW-1:0]        scan_addr_r, scan_addr_nxt;
  logic                 issue_r, issue_nxt;
  logic                 vld_r, vld_nxt;
  logic                 last_r, last_nxt;
  logic [SW-1:0]        peak_r, peak_nxt;
  logic [GW-1:0]        needed_r, needed_nxt;
  logic [32:0]          rel_prod_r, rel_prod_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [SW-1:0]        left_res_r, left_res_nxt;
  logic [SW-1:0]        right_res_r, right_res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [63:0]          out_data_r, out_data_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [MW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [MW-1:0]        ram_rdata;

  lpl_pkg::div_req_t    div_req;
  lpl_pkg::div_rsp_t    div_rsp;

  logic                 scan_at_last;
  logic                 over_limit;
  logic                 can_push;
  logic [LCW-1:0]       pos_inc;
  logic [GW:0]          coef;
  logic [SW-1:0]        mag_l;
  logic [SW-1:0]        mag_r;
  logic [SW-1:0]        peak_cand;

  assign scan_at_last = (LCW'(scan_addr_r) == last_idx);
  assign over_limit   = (peak_r > {ceil_r, 8'd0});
  assign can_push     = !out_valid_r || out_tready;
  assign pos_inc      = LCW'(pos_r) + LCW'(1);
  assign coef         = 17'h10000 - {1'b0, rel_coef_r};
  assign mag_l        = mag(ram_rdata[SW-1:0]);
  assign mag_r        = stereo_r ? mag(ram_rdata[MW-1:SW]) : '0;
  assign peak_cand    = (mag_r > mag_l) ? mag_r : mag_l;

  lpl_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_LOOKAHEAD)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpl_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(MAX_LOOKAHEAD - 1)) begin
          state_nxt = lpl_pkg::ST_IDLE;
        end
      end
      lpl_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = lpl_pkg::ST_READ;
        end
      end
      lpl_pkg::ST_READ:  state_nxt = lpl_pkg::ST_WRITE;
      lpl_pkg::ST_WRITE: state_nxt = lpl_pkg::ST_SCAN;
      lpl_pkg::ST_SCAN: begin
        if (vld_r && last_r) begin
          state_nxt = lpl_pkg::ST_DECIDE;
        end
      end
      lpl_pkg::ST_DECIDE: begin
        state_nxt = over_limit ? lpl_pkg::ST_DIV_WAIT : lpl_pkg::ST_REL_MUL;
      end
      lpl_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = lpl_pkg::ST_REL_MUL;
        end
      end
      lpl_pkg::ST_REL_MUL: begin
        state_nxt = (needed_r < att_r) ? lpl_pkg::ST_MUL_L : lpl_pkg::ST_REL_ADD;
      end
      lpl_pkg::ST_REL_ADD: state_nxt = lpl_pkg::ST_MUL_L;
      lpl_pkg::ST_MUL_L:   state_nxt = lpl_pkg::ST_SAT_L;
      lpl_pkg::ST_SAT_L: begin
        state_nxt = stereo_r ? lpl_pkg::ST_MUL_R : lpl_pkg::ST_PUSH;
      end
      lpl_pkg::ST_MUL_R:   state_nxt = lpl_pkg::ST_SAT_R;
      lpl_pkg::ST_SAT_R:   state_nxt = lpl_pkg::ST_PUSH;
      lpl_pkg::ST_PUSH: begin
        if (can_push) begin
          state_nxt = lpl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpl_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath and memory control
  // ---------------------------------------------------------------------
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    pos_nxt       = pos_r;
    att_nxt       = att_r;
    l_in_nxt      = l_in_r;
    r_in_nxt      = r_in_r;
    l_old_nxt     = l_old_r;
    r_old_nxt     = r_old_r;
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    vld_nxt       = 1'b0;
    last_nxt      = 1'b0;
    peak_nxt      = peak_r;
    needed_nxt    = needed_r;
    rel_prod_nxt  = rel_prod_r;
    prod_nxt      = prod_r;
    left_res_nxt  = left_res_r;
    right_res_nxt = right_res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = {stereo_r ? r_in_r : l_in_r, l_in_r};
    ram_re    = 1'b0;
    ram_raddr = pos_r;

    div_req.start   = 1'b0;
    div_req.ceiling = ceil_r;
    div_req.peak    = peak_r;

    case (state_r)
      lpl_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      lpl_pkg::ST_IDLE: begin
        l_in_nxt = in_tdata[SW-1:0];
        r_in_nxt = in_tdata[MW-1:SW];
      end
      lpl_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      lpl_pkg::ST_WRITE: begin
        // capture the outgoing pair, store the new one, start the scan
        l_old_nxt     = ram_rdata[SW-1:0];
        r_old_nxt     = ram_rdata[MW-1:SW];
        ram_we        = 1'b1;
        pos_nxt       = (pos_inc >= len_eff) ? '0 : AW'(pos_inc);
        scan_addr_nxt = '0;
        issue_nxt     = 1'b1;
        peak_nxt      = '0;
      end
      lpl_pkg::ST_SCAN: begin
        if (issue_r) begin
          ram_re    = 1'b1;
          ram_raddr = scan_addr_r;
          if (scan_at_last) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + AW'(1);
          end
        end
        vld_nxt  = issue_r;
        last_nxt = issue_r && scan_at_last;
        if (vld_r && (peak_cand > peak_r)) begin
          peak_nxt = peak_cand;
        end
      end
      lpl_pkg::ST_DECIDE: begin
        if (over_limit) begin
          div_req.start = 1'b1;
        end else begin
          needed_nxt = lpl_pkg::UNITY_GAIN;
        end
      end
      lpl_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          needed_nxt = div_rsp.quotient;
        end
      end
      lpl_pkg::ST_REL_MUL: begin
        // attack at once, else form the release step
        if (needed_r < att_r) begin
          att_nxt = needed_r;
        end else begin
          rel_prod_nxt = 33'(needed_r - att_r) * 33'(coef);
        end
      end
      lpl_pkg::ST_REL_ADD: begin
        att_nxt = att_r + GW'((rel_prod_r + 33'd65535) >> 16);
      end
      lpl_pkg::ST_MUL_L: begin
        prod_nxt = $signed(l_old_r) * $signed({1'b0, att_r});
      end
      lpl_pkg::ST_SAT_L: begin
        left_res_nxt = round_sat(prod_r);
      end
      lpl_pkg::ST_MUL_R: begin
        prod_nxt = $signed(r_old_r) * $signed({1'b0, att_r});
      end
      lpl_pkg::ST_SAT_R: begin
        right_res_nxt = round_sat(prod_r);
      end
      lpl_pkg::ST_PUSH: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {att_r, stereo_r ? right_res_r : '0, left_res_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpl_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      pos_r       <= '0;
      att_r       <= lpl_pkg::UNITY_GAIN;
      issue_r     <= 1'b0;
      vld_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pos_r       <= pos_nxt;
      att_r       <= att_nxt;
      issue_r     <= issue_nxt;
      vld_r       <= vld_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    l_in_r      <= l_in_nxt;
    r_in_r      <= r_in_nxt;
    l_old_r     <= l_old_nxt;
    r_old_r     <= r_old_nxt;
    scan_addr_r <= scan_addr_nxt;
    peak_r      <= peak_nxt;
    needed_r    <= needed_nxt;
    rel_prod_r  <= rel_prod_nxt;
    prod_r      <= prod_nxt;
    left_res_r  <= left_res_nxt;
    right_res_r <= right_res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_tready  = (state_r == lpl_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### test/tb_lookahead_peak_limiter_unit.sv
`timescale 1ns / 100ps

module tb_lookahead_peak_limiter_unit;

  localparam int LINE_DEPTH     = 256;
  localparam int WATCHDOG_LIMIT = 20000;  // idle cycles before giving up
  localparam int RX_HOLD_CYCLES = 3000;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES   = 400;    // a little over the slowest word

  // shapes of the random program material, one shape per stretch of words
  typedef enum int {
    SIG_FULL,
    SIG_QUIET,
    SIG_NEAR_CEILING,
    SIG_SILENT,
    SIG_EXTREME
  } sig_kind_t;

  typedef struct {
    logic [lpl_pkg::SAMPLE_W-1:0] left;
    logic [lpl_pkg::SAMPLE_W-1:0] right;
    logic [lpl_pkg::GAIN_W-1:0]   gain;
  } limited_pair_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;     // [23:0] left_in, [47:24] right_in
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [63:0] out_tdata;            // [23:0] left_out, [47:24] right_out, [63:48] gain
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor copy of the limiter: registers, delay lines, write slot, gain
  logic [lpl_pkg::GAIN_W-1:0]   ceil_q15    = 16'd29205;
  logic [lpl_pkg::GAIN_W-1:0]   release_q16 = 16'd65518;
  logic [8:0]                   window_len  = 9'd240;
  bit                           stereo_on   = 1'b1;
  logic [lpl_pkg::SAMPLE_W-1:0] delay_left_mem  [LINE_DEPTH];
  logic [lpl_pkg::SAMPLE_W-1:0] delay_right_mem [LINE_DEPTH];
  int unsigned                  head_pos = 0;
  int unsigned                  gain_q15 = 32768;

  logic [47:0]   pending_pairs[$];   // words waiting for the driver
  limited_pair_t expected_pairs[$];  // limited pairs still owed by the block
  limited_pair_t next_pair;

  // pacing controls, set by the sequence at falling edges; the monitor updates rx_hold_seen
  bit tx_gaps_on  = 1'b0;
  bit rx_gaps_on  = 1'b0;
  bit rx_hold_go  = 1'b0;
  bit rx_hold_seen = 1'b0;

  int unsigned tx_idle_left = 0;
  int unsigned rx_idle_left = 0;
  int unsigned stall_cycles = 0;
  int          fail_count   = 0;
  int          words_sent   = 0;
  int          words_checked = 0;
  int          settings_applied = 0;
  int          holds_done   = 0;

  always #6 clk = ~clk;

  lookahead_peak_limiter_unit #(
    .MAX_LOOKAHEAD(LINE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Append a word to the driver's queue.
  function automatic void queue_word(input logic [47:0] w);
    pending_pairs.insert(pending_pairs.size(), w);
  endfunction

  // Mostly back-to-back, some short pauses, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 98) return $urandom_range(4, 20);
    else return $urandom_range(50, 200);
  endfunction

  // Magnitude of a 24-bit sample; the most negative value gives 2^23.
  function automatic int unsigned abs24(input logic [lpl_pkg::SAMPLE_W-1:0] s);
    int v;
    v = int'($signed(s));
    return (v < 0) ? unsigned'(-v) : unsigned'(v);
  endfunction

  // Scale by the current gain, round half up, clamp to 24 bits.
  function automatic logic [lpl_pkg::SAMPLE_W-1:0] scale_sample(
      input logic [lpl_pkg::SAMPLE_W-1:0] s);
    longint prod;
    prod = longint'($signed(s)) * longint'(gain_q15);
    prod = (prod + 16384) >>> 15;
    if (prod > 8388607) prod = 8388607;
    if (prod < -8388608) prod = -8388608;
    return prod[lpl_pkg::SAMPLE_W-1:0];
  endfunction

  // Advance the limiter by one stereo pair and queue the pair it must emit.
  function automatic void limit_pair(input logic [47:0] word);
    int unsigned                  span;
    int unsigned                  slot;
    int unsigned                  peak;
    logic [lpl_pkg::SAMPLE_W-1:0] old_l;
    logic [lpl_pkg::SAMPLE_W-1:0] old_r;
    longint unsigned              needed;
    longint unsigned              step;
    limited_pair_t                res;
    span = window_len;
    if (span < lpl_pkg::MIN_LOOKAHEAD) span = lpl_pkg::MIN_LOOKAHEAD;
    if (span > LINE_DEPTH) span = LINE_DEPTH;
    // a slot left past a shrunken window is still used once, then wraps
    slot  = head_pos;
    old_l = delay_left_mem[slot];
    old_r = delay_right_mem[slot];
    delay_left_mem[slot]  = word[23:0];
    delay_right_mem[slot] = stereo_on ? word[47:24] : word[23:0];
    head_pos = (slot + 1 >= span) ? 0 : slot + 1;

    peak = 0;
    for (int j = 0; j < span; j++) begin
      if (abs24(delay_left_mem[j]) > peak) peak = abs24(delay_left_mem[j]);
      if (stereo_on && abs24(delay_right_mem[j]) > peak) peak = abs24(delay_right_mem[j]);
    end

    if (longint'(peak) > (longint'(ceil_q15) << 8))
      needed = (longint'(ceil_q15) << 23) / peak;
    else
      needed = lpl_pkg::UNITY_GAIN;

    // attack at once, release by at least one step toward the target
    if (needed < gain_q15) begin
      gain_q15 = 32'(needed);
    end else begin
      step = ((needed - gain_q15) * (65536 - longint'(release_q16)) + 65535) >> 16;
      gain_q15 = 32'(gain_q15 + step);
    end

    res.left  = scale_sample(old_l);
    res.right = stereo_on ? scale_sample(old_r) : '0;
    res.gain  = gain_q15[lpl_pkg::GAIN_W-1:0];
    expected_pairs.insert(expected_pairs.size(), res);
  endfunction

  // Driver: offer queued words, hold each until taken, then maybe pause.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      tx_idle_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        limit_pair(in_tdata);
        words_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_idle_left != 0) begin
          in_tvalid    <= 1'b0;
          tx_idle_left <= tx_idle_left - 1;
        end else if (pending_pairs.size() != 0) begin
          in_tdata     <= pending_pairs.pop_front();
          in_tvalid    <= 1'b1;
          tx_idle_left <= tx_gaps_on ? pick_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result word with the oldest prediction,
  // and pace out_tready, including the long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_idle_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_checked++;
        if (expected_pairs.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          fail_count++;
        end else begin
          next_pair = expected_pairs.pop_front();
          if (out_tdata[23:0] !== next_pair.left) begin
            $error("left_out mismatch: expected %0d, got %0d",
                   $signed(next_pair.left), $signed(out_tdata[23:0]));
            fail_count++;
          end
          if (out_tdata[47:24] !== next_pair.right) begin
            $error("right_out mismatch: expected %0d, got %0d",
                   $signed(next_pair.right), $signed(out_tdata[47:24]));
            fail_count++;
          end
          if (out_tdata[63:48] !== next_pair.gain) begin
            $error("applied_gain mismatch: expected %0d, got %0d",
                   next_pair.gain, out_tdata[63:48]);
            fail_count++;
          end
        end
      end
      if (rx_hold_go != rx_hold_seen) begin
        rx_hold_seen <= rx_hold_go;
        rx_idle_left <= RX_HOLD_CYCLES;
        out_tready   <= 1'b0;
        holds_done++;
      end else if (rx_idle_left != 0) begin
        rx_idle_left <= rx_idle_left - 1;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (rx_gaps_on && $urandom_range(0, 2) == 0) rx_idle_left <= pick_gap();
      end
    end
  end

  // Watchdog: stop the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** lookahead_peak_limiter_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Write one register through setup and access; mirror it in the predictor.
  task automatic cfg_write(input lpl_pkg::reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      lpl_pkg::REG_CEILING:   ceil_q15    = value[15:0];
      lpl_pkg::REG_RELEASE:   release_q16 = value[15:0];
      lpl_pkg::REG_LOOKAHEAD: window_len  = value[8:0];
      lpl_pkg::REG_STEREO:    stereo_on   = value[0];
      default: ;
    endcase
  endtask

  // Wait until the driver is empty and every predicted pair has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_tvalid || expected_pairs.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [lpl_pkg::SAMPLE_W-1:0] draw_sample(input sig_kind_t kind);
    int level;
    case (kind)
      SIG_FULL:  return 24'($urandom());
      SIG_QUIET: return 24'(int'($urandom_range(0, 131070)) - 65535);
      SIG_NEAR_CEILING: begin
        // hover around the ceiling so the limiter toggles between attack and release
        level = int'(ceil_q15) * 256 + int'($urandom_range(0, 8192)) - 4096;
        if (level > 8388607) level = 8388607;
        if (level < 0) level = 0;
        return $urandom_range(0, 1) ? 24'(level) : 24'(-level);
      end
      SIG_SILENT: return '0;
      default: begin
        case ($urandom_range(0, 4))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h800001;
          3: return 24'h000001;
          default: return 24'hFFFFFF;
        endcase
      end
    endcase
  endfunction

  // One program segment: configure, feed stretches of shaped audio, drain.
  task automatic run_phase(input logic [15:0] ceil, input logic [15:0] rel,
                           input logic [8:0] len, input bit stereo,
                           input int n_words, input bit gaps, input bit squeeze);
    sig_kind_t kind;
    int        seg_left;
    kind     = SIG_FULL;
    seg_left = 0;
    cfg_write(lpl_pkg::REG_CEILING, 32'(ceil));
    cfg_write(lpl_pkg::REG_RELEASE, 32'(rel));
    cfg_write(lpl_pkg::REG_LOOKAHEAD, 32'(len));
    cfg_write(lpl_pkg::REG_STEREO, 32'(stereo));
    settings_applied++;
    @(negedge clk);
    tx_gaps_on = gaps && !squeeze;
    rx_gaps_on = gaps;
    // squeeze: receiver goes quiet while the sender keeps pushing
    if (squeeze) rx_hold_go = ~rx_hold_go;
    for (int i = 0; i < n_words; i++) begin
      if (seg_left == 0) begin
        kind     = sig_kind_t'($urandom_range(0, 4));
        seg_left = $urandom_range(4, 40);
      end
      seg_left--;
      queue_word({draw_sample(kind), draw_sample(kind)});
    end
    wait_idle();
  endtask

  initial begin
    for (int j = 0; j < LINE_DEPTH; j++) begin
      delay_left_mem[j]  = '0;
      delay_right_mem[j] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings: full scale both ways, the most
    // negative code on each side, tiny values, and peaks just around the
    // default ceiling (29205 * 256) so the gain sits right at the threshold.
    @(negedge clk);
    queue_word({24'h000000, 24'h000000});
    queue_word({24'h7FFFFF, 24'h7FFFFF});
    queue_word({24'h800000, 24'h800000});
    queue_word({24'h7FFFFF, 24'h800000});
    queue_word({24'h800000, 24'h7FFFFF});
    queue_word({24'h000001, 24'hFFFFFF});
    queue_word({24'hFFFFFF, 24'h000001});
    queue_word({24'h800000, 24'h000000});
    queue_word({24'h000000, 24'h721500});
    queue_word({24'h000000, 24'h721501});
    queue_word({24'h8DEAFF, 24'h000000});
    queue_word({24'h555555, 24'hAAAAAA});
    queue_word({24'hAAAAAA, 24'h555555});
    for (int j = 0; j < 5; j++) queue_word({24'h000000, 24'h000000});
    wait_idle();

    // Corner settings: unity ceiling with instant release on the shortest
    // window (write slot now past the window), mono with a ceiling of 3277
    // and slowest release on the longest window, zero ceiling with a window
    // below range, ceiling above unity with a window above range.
    run_phase(16'd32768, 16'd0,     9'd16,  1'b1, 80, 1'b1, 1'b0);
    run_phase(16'd3277,  16'd65535, 9'd256, 1'b0, 40, 1'b0, 1'b0);
    run_phase(16'd0,     16'd40000, 9'd5,   1'b1, 60, 1'b1, 1'b0);
    run_phase(16'd65535, 16'd60000, 9'd511, 1'b1, 30, 1'b0, 1'b0);

    // Back-pressure: hold the receiver long enough that input stalls.
    run_phase(16'd16384, 16'd65000, 9'd32, 1'b1, 60, 1'b1, 1'b1);

    // Random settings, mostly short windows to keep the run quick.
    for (int k = 0; k < 10; k++) begin
      run_phase(16'($urandom_range(3277, 32768)),
                $urandom_range(0, 1) ? 16'($urandom_range(60000, 65535))
                                     : 16'($urandom_range(0, 65535)),
                9'($urandom_range(16, 64)), 1'($urandom_range(0, 1)), 55,
                $urandom_range(0, 2) != 0, 1'b0);
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run covered %0d stereo pairs under %0d register settings, %0d results checked",
             words_sent, settings_applied + 1, words_checked);
    $display("long receiver hold-offs: %0d, mismatches: %0d", holds_done, fail_count);
    if (fail_count == 0) begin
      $display("** lookahead_peak_limiter_unit: PASSED **");
    end else begin
      $display("** lookahead_peak_limiter_unit: FAILED **");
    end
    $finish;
  end

endmodule

### lookahead_peak_limiter_unit.f
rtl/lpl_pkg.sv
rtl/lpl_ram.sv
rtl/lpl_div.sv
rtl/lookahead_peak_limiter_unit.sv
test/tb_lookahead_peak_limiter_unit.sv
